### hw/rtl/lpc_pkg.sv
package lpc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int ALU_W = 34;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_ADJUST = 2'd3
	} lpc_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LK_C0,
		ST_LK_CL,
		ST_LK_CJ,
		ST_LK_B,
		ST_LK_A,
		ST_LK_S,
		ST_EV_0,
		ST_EV_1,
		ST_EV_2,
		ST_EV_K,
		ST_EV_CMP,
		ST_EV_E,
		ST_DR_R,
		ST_DR_W,
		ST_IS_R,
		ST_IS_C,
		ST_CL_R,
		ST_CL_C,
		ST_AF_R,
		ST_AF_C,
		ST_AP_R,
		ST_AP_C,
		ST_MV0,
		ST_MV_R,
		ST_MV_W,
		ST_FIN
	} lpc_state_t;

endpackage

### hw/rtl/lpc_ram.sv
module lpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hw/rtl/lpc_alu.sv
module lpc_alu (
	input  logic signed [lpc_pkg::ALU_W-1:0] a,
	input  logic signed [lpc_pkg::ALU_W-1:0] b,
	output logic signed [lpc_pkg::ALU_W-1:0] diff,
	output logic                             neg,
	output logic                             pos
);
	import lpc_pkg::*;

	always_comb begin
		diff = a - b;
		neg  = diff[ALU_W-1];
		pos  = !diff[ALU_W-1] && (diff != '0);
	end
endmodule

### hw/rtl/line_position_cache_table_unit.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | cmd, key_pos, line_number, old_length, new_length, line_delta
// output  | out_valid / out_stall| found, near_pos, near_line, entry_count
//
// One item is taken at a time; in_stall stays high until its result is registered.
// A command walks the stored pairs through one RAM read port and one subtractor.
// The slowest item is an insert into a nearly full table (eviction scan, gap close,
// sorted insert).
// Reset clears the state, the entry count and the result valid; RAM contents are never
// read before written.
// A pending result may sit in the output register while the next item is taken.
module line_position_cache_table_unit #(
	parameter int ENTRIES = lpc_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic [31:0]                  key_pos,
	input  logic [31:0]                  line_number,
	input  logic [31:0]                  old_length,
	input  logic [31:0]                  new_length,
	input  logic signed [31:0]           line_delta,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [31:0]                  near_pos,
	output logic [31:0]                  near_line,
	output logic [$clog2(ENTRIES+1)-1:0] entry_count
);
	import lpc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES+1);

	lpc_state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q, first_q, best_q, rem_q;
	logic [31:0]   key_q, ln_q, shift_q, dl_q;
	logic [32:0]   end_q;
	logic [31:0]   pa_q, la_q, cp_q, cl_q, p1_q, p2_q;
	logic signed [ALU_W-1:0] tmp_q, bspan_q;
	logic          res_found_q;
	logic [31:0]   res_pos_q, res_line_q;
	logic          out_valid_q;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_wa, ram_ra;
	logic [63:0]   ram_wd, rdata;
	logic [31:0]   rd_pos, rd_line;

	logic signed [ALU_W-1:0] alu_a, alu_b, diff;
	logic          dneg, dpos;

	logic [CW-1:0] lastw;
	logic [IW-1:0] last_i;
	logic [CW-1:0] idx_x, idx_n;
	logic          accept, load_out;

	assign rd_pos  = rdata[63:32];
	assign rd_line = rdata[31:0];
	assign lastw   = cnt_q - CW'(1);
	assign last_i  = lastw[IW-1:0];
	assign idx_x   = CW'(idx_q);
	assign idx_n   = idx_x + CW'(1);
	assign in_stall = (state_q != ST_IDLE);
	assign accept  = in_valid && !in_stall;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	lpc_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (rdata)
	);

	lpc_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (diff),
		.neg  (dneg),
		.pos  (dpos)
	);

	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		ram_wa  = '0;
		ram_wd  = '0;
		ram_re  = 1'b0;
		ram_ra  = '0;
		alu_a   = '0;
		alu_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (lpc_cmd_t'(cmd))
						CMD_LOOKUP: begin
							if (cnt_q == '0) begin
								state_d = ST_FIN;
							end else begin
								ram_re  = 1'b1;
								state_d = ST_LK_C0;
							end
						end
						CMD_INSERT: begin
							if (cnt_q >= CW'(ENTRIES - 1)) begin
								ram_re  = 1'b1;
								state_d = ST_EV_0;
							end else begin
								state_d = ST_IS_R;
							end
						end
						CMD_CLEAR:  state_d = ST_CL_R;
						CMD_ADJUST: state_d = ST_AF_R;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LK_C0: begin
				alu_a = {2'b00, key_q};
				alu_b = {2'b00, rd_pos};
				if (cnt_q == CW'(1) || !dpos) begin
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					ram_ra  = last_i;
					state_d = ST_LK_CL;
				end
			end
			ST_LK_CL: begin
				alu_a = {2'b00, key_q};
				alu_b = {2'b00, rd_pos};
				if (!dneg) begin
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					ram_ra  = IW'(1);
					state_d = ST_LK_CJ;
				end
			end
			ST_LK_CJ: begin
				alu_a = {2'b00, key_q};
				alu_b = {2'b00, rd_pos};
				if (idx_q < last_i && dpos) begin
					ram_re = 1'b1;
					ram_ra = idx_q + IW'(1);
				end else begin
					state_d = ST_LK_B;
				end
			end
			ST_LK_B: begin
				alu_a   = {2'b00, key_q};
				alu_b   = {2'b00, pa_q};
				state_d = ST_LK_A;
			end
			ST_LK_A: begin
				alu_a   = {2'b00, cp_q};
				alu_b   = {2'b00, key_q};
				state_d = ST_LK_S;
			end
			ST_LK_S: begin
				alu_a   = tmp_q;
				alu_b   = bspan_q;
				state_d = ST_FIN;
			end
			ST_EV_0: begin
				ram_re  = 1'b1;
				ram_ra  = IW'(1);
				state_d = ST_EV_1;
			end
			ST_EV_1: begin
				ram_re  = 1'b1;
				ram_ra  = IW'(2);
				state_d = ST_EV_2;
			end
			ST_EV_2: begin
				alu_a = {2'b00, rd_pos};
				alu_b = {2'b00, p2_q};
				if (CW'(3) < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = IW'(3);
					state_d = ST_EV_K;
				end else begin
					state_d = ST_EV_E;
				end
			end
			ST_EV_K: begin
				alu_a   = {2'b00, rd_pos};
				alu_b   = {2'b00, p2_q};
				state_d = ST_EV_CMP;
			end
			ST_EV_CMP: begin
				alu_a = tmp_q;
				alu_b = bspan_q;
				if (idx_n < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = idx_q + IW'(1);
					state_d = ST_EV_K;
				end else begin
					state_d = ST_EV_E;
				end
			end
			ST_EV_E: state_d = ST_DR_R;
			ST_DR_R: begin
				if (idx_x < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = idx_q;
					state_d = ST_DR_W;
				end else begin
					state_d = ST_IS_R;
				end
			end
			ST_DR_W: begin
				ram_we  = 1'b1;
				ram_wa  = idx_q - IW'(1);
				ram_wd  = rdata;
				state_d = ST_DR_R;
			end
			ST_IS_R: begin
				if (idx_q == '0) begin
					ram_we  = 1'b1;
					ram_wd  = {key_q, ln_q};
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					ram_ra  = idx_q - IW'(1);
					state_d = ST_IS_C;
				end
			end
			ST_IS_C: begin
				alu_a  = {2'b00, key_q};
				alu_b  = {2'b00, rd_pos};
				ram_we = 1'b1;
				ram_wa = idx_q;
				if (dpos) begin
					ram_wd  = {key_q, ln_q};
					state_d = ST_FIN;
				end else begin
					ram_wd  = rdata;
					state_d = ST_IS_R;
				end
			end
			ST_CL_R: begin
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					ram_ra  = last_i;
					state_d = ST_CL_C;
				end
			end
			ST_CL_C: begin
				alu_a   = {2'b00, rd_pos};
				alu_b   = {2'b00, key_q};
				state_d = dneg ? ST_FIN : ST_CL_R;
			end
			ST_AF_R: begin
				if (idx_x < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = idx_q;
					state_d = ST_AF_C;
				end else begin
					state_d = ST_MV0;
				end
			end
			ST_AF_C: begin
				alu_a   = {2'b00, rd_pos};
				alu_b   = {2'b00, key_q};
				state_d = dneg ? ST_AF_R : ST_AP_C;
			end
			ST_AP_R: begin
				if (idx_x < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = idx_q;
					state_d = ST_AP_C;
				end else begin
					state_d = ST_MV0;
				end
			end
			ST_AP_C: begin
				alu_a   = {2'b00, rd_pos};
				alu_b   = {1'b0, end_q};
				state_d = dneg ? ST_AP_R : ST_MV0;
			end
			ST_MV0: state_d = ST_MV_R;
			ST_MV_R: begin
				if (idx_x < cnt_q) begin
					ram_re  = 1'b1;
					ram_ra  = idx_q;
					state_d = ST_MV_W;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MV_W: begin
				ram_we  = 1'b1;
				ram_wa  = idx_q - rem_q;
				ram_wd  = {rd_pos + shift_q, rd_line + dl_q};
				state_d = ST_MV_R;
			end
			ST_FIN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry count and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DR_R: begin
					if (!(idx_x < cnt_q)) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_IS_R: begin
					if (idx_q == '0) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IS_C: begin
					if (dpos) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_CL_C: begin
					if (!dneg) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_MV_R: begin
					if (!(idx_x < cnt_q)) begin
						cnt_q <= cnt_q - CW'(rem_q);
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q       <= key_pos;
					ln_q        <= line_number;
					shift_q     <= new_length - old_length;
					dl_q        <= line_delta;
					end_q       <= {1'b0, key_pos} + {1'b0, old_length};
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
					res_line_q  <= '0;
					if (lpc_cmd_t'(cmd) == CMD_INSERT && cnt_q < CW'(ENTRIES - 1)) begin
						idx_q <= cnt_q[IW-1:0];
					end else begin
						idx_q <= '0;
					end
				end
			end
			ST_LK_C0: begin
				pa_q <= rd_pos;
				la_q <= rd_line;
				if (cnt_q == CW'(1) || !dpos) begin
					res_found_q <= 1'b1;
					res_pos_q   <= rd_pos;
					res_line_q  <= rd_line;
				end
			end
			ST_LK_CL: begin
				idx_q <= IW'(1);
				if (!dneg) begin
					res_found_q <= 1'b1;
					res_pos_q   <= rd_pos;
					res_line_q  <= rd_line;
				end
			end
			ST_LK_CJ: begin
				if (idx_q < last_i && dpos) begin
					pa_q  <= rd_pos;
					la_q  <= rd_line;
					idx_q <= idx_q + IW'(1);
				end else begin
					cp_q <= rd_pos;
					cl_q <= rd_line;
				end
			end
			ST_LK_B: tmp_q <= diff;
			ST_LK_A: bspan_q <= diff;
			ST_LK_S: begin
				// The lower neighbor wins only when strictly closer.
				res_found_q <= 1'b1;
				res_pos_q   <= dneg ? pa_q : cp_q;
				res_line_q  <= dneg ? la_q : cl_q;
			end
			ST_EV_0: p2_q <= rd_pos;
			ST_EV_1: p1_q <= rd_pos;
			ST_EV_2: begin
				bspan_q <= diff;
				best_q  <= IW'(2);
				p2_q    <= p1_q;
				p1_q    <= rd_pos;
				idx_q   <= IW'(3);
			end
			ST_EV_K: begin
				tmp_q <= diff;
				p2_q  <= p1_q;
				p1_q  <= rd_pos;
			end
			ST_EV_CMP: begin
				if (dneg) begin
					best_q  <= idx_q;
					bspan_q <= tmp_q;
				end
				idx_q <= idx_q + IW'(1);
			end
			ST_EV_E: idx_q <= best_q;
			ST_DR_R: begin
				if (!(idx_x < cnt_q)) begin
					idx_q <= last_i;
				end
			end
			ST_DR_W: idx_q <= idx_q + IW'(1);
			ST_IS_C: begin
				if (!dpos) begin
					idx_q <= idx_q - IW'(1);
				end
			end
			ST_AF_R: first_q <= idx_q;
			ST_AF_C: begin
				if (dneg) begin
					idx_q <= idx_q + IW'(1);
				end else begin
					first_q <= idx_q;
				end
			end
			ST_AP_C: begin
				if (dneg) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ST_MV0: rem_q <= idx_q - first_q;
			ST_MV_W: idx_q <= idx_q + IW'(1);
			ST_FIN: begin
				if (load_out) begin
					found       <= res_found_q;
					near_pos    <= res_pos_q;
					near_line   <= res_line_q;
					entry_count <= cnt_q;
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

### hw/rtl/lpc_checker.sv
module lpc_checker #(
	parameter int ENTRIES = lpc_pkg::ENTRIES_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic [31:0]                  near_pos,
	input logic [31:0]                  near_line,
	input logic [$clog2(ENTRIES+1)-1:0] entry_count
);
	import lpc_pkg::*;

	// An accepted item always occupies the block and raises in_stall, so no second item is taken behind it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(near_pos) && $stable(entry_count)))
		else $error("stalled result changed");

	a_zero_when_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (near_pos == '0 && near_line == '0))
		else $error("result without a hit carries data");

	// Eviction keeps the table below its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count < ($clog2(ENTRIES+1))'(ENTRIES)))
		else $error("entry count reached capacity");
endmodule

bind line_position_cache_table_unit lpc_checker #(.ENTRIES(ENTRIES)) u_lpc_checker (.*);
